>>> rtl/lookahead_min_slot_replacement_unit_macros.svh
// Assertion macros shared by the lookahead MIN slot replacement unit.
`ifndef LOOKAHEAD_MIN_SLOT_REPLACEMENT_UNIT_MACROS_SVH
`define LOOKAHEAD_MIN_SLOT_REPLACEMENT_UNIT_MACROS_SVH

// Check an implication on every rising clock edge, off while reset is low.
`define LMSR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition holds whenever the result strobe is high.
`define LMSR_ASSERT_ON_RESULT(lbl, clk, rstn, strobe, cond, msg) \
  `LMSR_ASSERT(lbl, clk, rstn, (strobe |-> (cond)), msg)

`endif

>>> rtl/lmsr_pkg.sv
`timescale 1ns / 1ps
package lmsr_pkg;

  localparam int NUM_SLOT   = 64;
  localparam int IDX_W      = $clog2(NUM_SLOT);
  localparam int ROW_W      = 24;
  localparam int PART_W     = 8;
  localparam int TAG_W      = ROW_W + PART_W;
  localparam int BYTES_W    = 12;
  localparam int WEIGHT_W   = 32;
  localparam int CNT_W      = 48;
  localparam int SLOT_W     = 6;
  localparam int OUTCOME_W  = 2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_HIT    = 2'd0,
    OUTCOME_FILL   = 2'd1,
    OUTCOME_BYPASS = 2'd2
  } outcome_e;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic                vld;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                has_best;
    logic                best_vld;
    logic [WEIGHT_W-1:0] best_w;
    logic [IDX_W-1:0]    best_idx;
  } carry_t;

  // Slot update broadcast to all cells.
  typedef struct packed {
    logic                en;
    logic                fill;
    logic [IDX_W-1:0]    idx;
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] weight;
  } wr_t;

endpackage

>>> rtl/lookahead_min_slot_replacement_unit.sv
// One transaction at a time: busy_o is high from the accepting edge until the done_o
// strobe, so no new transaction is taken before the result. The launch register seeds the record,
//   which walks the cell chain one slot per cycle, and the slot update lands with the result.
// Reset (rst_ni low, asynchronous): all slots empty with weight all ones, both byte
//   counters zero, idle; no clearing pass. The receiver cannot stall: each result
//   is shown for exactly one cycle on done_o.
`timescale 1ns / 1ps
`include "lookahead_min_slot_replacement_unit_macros.svh"
module lookahead_min_slot_replacement_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [lmsr_pkg::ROW_W-1:0]       row_id_i,
  input  logic [lmsr_pkg::PART_W-1:0]      part_id_i,
  input  logic [lmsr_pkg::BYTES_W-1:0]     access_bytes_i,
  input  logic [lmsr_pkg::WEIGHT_W-1:0]    next_use_i,
  output logic                             done_o,
  output logic [lmsr_pkg::OUTCOME_W-1:0]   outcome_o,
  output logic [lmsr_pkg::SLOT_W-1:0]      slot_o,
  output logic                             evicted_o,
  output logic [lmsr_pkg::CNT_W-1:0]       miss_bytes_total_o,
  output logic [lmsr_pkg::CNT_W-1:0]       ref_bytes_total_o
);
  import lmsr_pkg::*;

  // Transaction control.
  logic                accept;
  logic                busy_q;
  logic                launch_q;
  logic                done_q;

  // Captured transaction.
  logic [TAG_W-1:0]    key_q;
  logic [WEIGHT_W-1:0] nu_q;
  logic [BYTES_W-1:0]  bytes_q;

  // Running byte counters.
  logic [CNT_W-1:0]    miss_cnt_q, miss_cnt_d;
  logic [CNT_W-1:0]    ref_cnt_q;

  // Result registers.
  outcome_e            outcome_q, outcome_d;
  logic [IDX_W-1:0]    res_idx_d;
  logic [SLOT_W-1:0]   slot_q;
  logic                evicted_q, evicted_d;
  logic [SLOT_W+IDX_W-1:0] slot_wide;

  // Cell chain: carry[k] feeds cell k, carry[NUM_SLOT] leaves the last cell.
  carry_t              carry [NUM_SLOT+1];
  carry_t              last;
  wr_t                 wr;

  assign accept = start_i && !busy_q;

  // Seed the search with an empty record in the cycle after the accept.
  always_comb begin
    carry[0]     = '0;
    carry[0].vld = launch_q;
  end

  for (genvar i = 0; i < NUM_SLOT; i++) begin : g_cell
    lmsr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .key_i      (key_q),
      .carry_i    (carry[i]),
      .carry_o    (carry[i+1]),
      .wr_i       (wr)
    );
  end

  assign last = carry[NUM_SLOT];

  // Decide the outcome once the record clears the chain. A hit refreshes the
  // weight; a miss fills the heaviest slot unless that slot is needed sooner
  // than this tag, in which case bypass and leave the slots alone.
  always_comb begin
    outcome_d  = OUTCOME_HIT;
    res_idx_d  = last.hit_idx;
    evicted_d  = 1'b0;
    miss_cnt_d = miss_cnt_q;
    wr         = '0;
    wr.tag     = key_q;
    wr.weight  = nu_q;
    if (last.hit) begin
      wr.en  = last.vld;
      wr.idx = last.hit_idx;
    end else begin
      miss_cnt_d = miss_cnt_q + CNT_W'(bytes_q);
      if (last.best_w < nu_q) begin
        outcome_d = OUTCOME_BYPASS;
        res_idx_d = '0;
      end else begin
        outcome_d = OUTCOME_FILL;
        res_idx_d = last.best_idx;
        evicted_d = last.best_vld;
        wr.en     = last.vld;
        wr.fill   = 1'b1;
        wr.idx    = last.best_idx;
      end
    end
  end

  // Slot field carries the low bits of the index.
  assign slot_wide = {{SLOT_W{1'b0}}, res_idx_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      launch_q   <= 1'b0;
      done_q     <= 1'b0;
      miss_cnt_q <= '0;
      ref_cnt_q  <= '0;
    end else begin
      launch_q <= accept;
      done_q   <= 1'b0;
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (last.vld) begin
        // Retire the transaction: update counters and raise the strobe.
        busy_q     <= 1'b0;
        done_q     <= 1'b1;
        miss_cnt_q <= miss_cnt_d;
        ref_cnt_q  <= ref_cnt_q + CNT_W'(bytes_q);
      end
    end
  end

  // Payload registers: hold the captured transaction and the last result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q   <= {row_id_i, part_id_i};
      nu_q    <= next_use_i;
      bytes_q <= access_bytes_i;
    end
    if (last.vld) begin
      outcome_q <= outcome_d;
      slot_q    <= slot_wide[SLOT_W-1:0];
      evicted_q <= evicted_d;
    end
  end

  assign busy_o             = busy_q;
  assign done_o             = done_q;
  assign outcome_o          = outcome_q;
  assign slot_o             = slot_q;
  assign evicted_o          = evicted_q;
  assign miss_bytes_total_o = miss_cnt_q;
  assign ref_bytes_total_o  = ref_cnt_q;

  // A result retires its transaction, so the unit is free with the strobe.
  `LMSR_ASSERT_ON_RESULT(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q, "done while busy")
  // An accepted transaction keeps the unit busy until its result.
  `LMSR_ASSERT(a_accept_busy, clk_i, rst_ni, (accept |=> (busy_q && !done_q)), "accept not held")
  // A bypass names no slot and evicts nothing.
  `LMSR_ASSERT_ON_RESULT(a_bypass_clean, clk_i, rst_ni, (done_q && (outcome_q == OUTCOME_BYPASS)), ((slot_q == '0) && !evicted_q), "bypass with slot or eviction")
  // Only a fill may evict.
  `LMSR_ASSERT_ON_RESULT(a_evict_fill, clk_i, rst_ni, (done_q && evicted_q), (outcome_q == OUTCOME_FILL), "eviction without fill")

endmodule

>>> rtl/lmsr_cell.sv
`timescale 1ns / 1ps
module lmsr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lmsr_pkg::IDX_W-1:0]    cell_idx_i,
  input  logic [lmsr_pkg::TAG_W-1:0]    key_i,
  input  lmsr_pkg::carry_t              carry_i,
  output lmsr_pkg::carry_t              carry_o,
  input  lmsr_pkg::wr_t                 wr_i
);
  import lmsr_pkg::*;

  logic [TAG_W-1:0]    tag_q;
  logic                valid_q;
  logic [WEIGHT_W-1:0] weight_q;
  carry_t              carry_d, carry_q;
  logic                wr_sel;

  assign wr_sel = wr_i.en && (wr_i.idx == cell_idx_i);

  // Merge this slot into the running search: first match wins, strictly
  // larger weight replaces the best so ties keep the lower index.
  always_comb begin
    carry_d = carry_i;
    if (carry_i.vld) begin
      if (!carry_i.hit && valid_q && (tag_q == key_i)) begin
        carry_d.hit     = 1'b1;
        carry_d.hit_idx = cell_idx_i;
      end
      if (!carry_i.has_best || (weight_q > carry_i.best_w)) begin
        carry_d.has_best = 1'b1;
        carry_d.best_vld = valid_q;
        carry_d.best_w   = weight_q;
        carry_d.best_idx = cell_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      weight_q <= '1;
      carry_q  <= '0;
    end else begin
      carry_q <= carry_d;
      if (wr_sel) begin
        weight_q <= wr_i.weight;
        if (wr_i.fill) begin
          valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel && wr_i.fill) begin
      tag_q <= wr_i.tag;
    end
  end

  assign carry_o = carry_q;

endmodule

>>> verif/lookahead_min_slot_replacement_unit_tb.sv
`timescale 1ns / 1ps
module lookahead_min_slot_replacement_unit_tb;
  import lmsr_pkg::*;

  localparam logic [WEIGHT_W-1:0] NEVER_USE    = 32'hFFFF_FFFE;
  localparam logic [WEIGHT_W-1:0] EMPTY_WEIGHT = 32'hFFFF_FFFF;
  localparam int NUM_DIRECTED   = 10;
  localparam int NUM_RANDOM     = 1200;
  localparam int TAG_POOL_DEPTH = 96;
  // Drain wait after the last result: one full pass of the cell chain plus margin.
  localparam int DRAIN_CYCLES   = 80;
  // Slowest legal run: ~1300 transactions, each up to the longest sender gap plus
  // its occupancy of the unit, then taken about four times over.
  localparam int CYCLE_LIMIT    = 800_000;

  // One directed access; when has_exp is set the hit/fill/bypass decision,
  // the slot and the eviction flag are typed in, the byte totals come from
  // the predictor.
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [PART_W-1:0]   part;
    logic [BYTES_W-1:0]  nbytes;
    logic [WEIGHT_W-1:0] next_use;
    logic                has_exp;
    outcome_e            exp_outcome;
    logic [SLOT_W-1:0]   exp_slot;
    logic                exp_evicted;
  } stim_row_t;

  typedef struct packed {
    outcome_e            outcome;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [CNT_W-1:0]    miss_total;
    logic [CNT_W-1:0]    ref_total;
  } access_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [ROW_W-1:0]       row_id_i;
  logic [PART_W-1:0]      part_id_i;
  logic [BYTES_W-1:0]     access_bytes_i;
  logic [WEIGHT_W-1:0]    next_use_i;
  logic                   done_o;
  logic [OUTCOME_W-1:0]   outcome_o;
  logic [SLOT_W-1:0]      slot_o;
  logic                   evicted_o;
  logic [CNT_W-1:0]       miss_bytes_total_o;
  logic [CNT_W-1:0]       ref_bytes_total_o;

  // Shadow copy of the cache: tags, valid bits, next-use weights, byte totals.
  logic [TAG_W-1:0]       shadow_tag    [NUM_SLOT];
  logic                   shadow_valid  [NUM_SLOT];
  logic [WEIGHT_W-1:0]    shadow_weight [NUM_SLOT];
  logic [CNT_W-1:0]       shadow_miss_bytes;
  logic [CNT_W-1:0]       shadow_ref_bytes;

  access_result_t         pending_results [$];
  access_result_t         oldest_result;
  int                     fault_count;
  int                     cycle_count;
  int                     burst_left;

  logic [ROW_W-1:0]       pool_row  [TAG_POOL_DEPTH];
  logic [PART_W-1:0]      pool_part [TAG_POOL_DEPTH];

  // Directed rows: extremes of every field, hits, fills into empty slots,
  // next use of zero and of never.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{24'h000000, 8'h00, 12'h000, NEVER_USE,    1'b1, OUTCOME_FILL, 6'd0, 1'b0},
    '{24'h000000, 8'h00, 12'hFFF, 32'h0000_0000, 1'b1, OUTCOME_HIT,  6'd0, 1'b0},
    '{24'hFFFFFF, 8'hFF, 12'hFFF, NEVER_USE,    1'b1, OUTCOME_FILL, 6'd1, 1'b0},
    '{24'hFFFFFF, 8'h00, 12'h001, 32'h0000_0000, 1'b1, OUTCOME_FILL, 6'd2, 1'b0},
    '{24'h000000, 8'hFF, 12'h800, 32'h8000_0000, 1'b1, OUTCOME_FILL, 6'd3, 1'b0},
    '{24'hAAAAAA, 8'h55, 12'hAAA, 32'h5555_5555, 1'b1, OUTCOME_FILL, 6'd4, 1'b0},
    '{24'h555555, 8'hAA, 12'h555, 32'hAAAA_AAAA, 1'b1, OUTCOME_FILL, 6'd5, 1'b0},
    '{24'hFFFFFF, 8'hFF, 12'h000, 32'h0000_0007, 1'b1, OUTCOME_HIT,  6'd1, 1'b0},
    '{24'h000000, 8'h00, 12'hFFF, NEVER_USE,    1'b1, OUTCOME_HIT,  6'd0, 1'b0},
    '{24'h123456, 8'h78, 12'h7FF, 32'h0000_0000, 1'b1, OUTCOME_FILL, 6'd6, 1'b0}
  };

  lookahead_min_slot_replacement_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .row_id_i           (row_id_i),
    .part_id_i          (part_id_i),
    .access_bytes_i     (access_bytes_i),
    .next_use_i         (next_use_i),
    .done_o             (done_o),
    .outcome_o          (outcome_o),
    .slot_o             (slot_o),
    .evicted_o          (evicted_o),
    .miss_bytes_total_o (miss_bytes_total_o),
    .ref_bytes_total_o  (ref_bytes_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic log_fault(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fault_count++;
  endtask

  // Work out one access on the shadow cache: match the tag, else pick the
  // slot with the latest next use (lowest index on ties), then fill or bypass.
  function automatic access_result_t predict_access(input logic [TAG_W-1:0] tag,
                                                    input logic [BYTES_W-1:0] nbytes,
                                                    input logic [WEIGHT_W-1:0] nu);
    access_result_t res;
    int hit_idx;
    int victim;
    logic [WEIGHT_W-1:0] victim_w;
    hit_idx  = -1;
    victim   = 0;
    victim_w = shadow_weight[0];
    res      = '0;
    shadow_ref_bytes = shadow_ref_bytes + CNT_W'(nbytes);
    for (int i = 0; i < NUM_SLOT; i++) begin
      if (hit_idx < 0 && shadow_valid[i] && shadow_tag[i] == tag) hit_idx = i;
      if (shadow_weight[i] > victim_w) begin
        victim   = i;
        victim_w = shadow_weight[i];
      end
    end
    if (hit_idx >= 0) begin
      shadow_weight[hit_idx] = nu;
      res.outcome = OUTCOME_HIT;
      res.slot    = SLOT_W'(hit_idx);
    end else begin
      shadow_miss_bytes = shadow_miss_bytes + CNT_W'(nbytes);
      if (victim_w < nu) begin
        res.outcome = OUTCOME_BYPASS;
      end else begin
        res.outcome           = OUTCOME_FILL;
        res.slot              = SLOT_W'(victim);
        res.evicted           = shadow_valid[victim];
        shadow_tag[victim]    = tag;
        shadow_valid[victim]  = 1'b1;
        shadow_weight[victim] = nu;
      end
    end
    res.miss_total = shadow_miss_bytes;
    res.ref_total  = shadow_ref_bytes;
    return res;
  endfunction

  // Present one access, honoring the sender's burst/gap pattern; hold it
  // until the block takes it, then record what it should return.
  task automatic send_access(input stim_row_t acc);
    access_result_t want;
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    start_i        <= 1'b1;
    row_id_i       <= acc.row;
    part_id_i      <= acc.part;
    access_bytes_i <= acc.nbytes;
    next_use_i     <= acc.next_use;
    do @(posedge clk_i); while (busy_o);
    want = predict_access({acc.row, acc.part}, acc.nbytes, acc.next_use);
    if (acc.has_exp) begin
      want.outcome = acc.exp_outcome;
      want.slot    = acc.exp_slot;
      want.evicted = acc.exp_evicted;
    end
    pending_results.insert(pending_results.size(), want);
  endtask

  // Check every strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        log_fault("result strobe with no transaction outstanding");
      end else begin
        oldest_result = pending_results[0];
        pending_results.delete(0);
        if (outcome_o !== oldest_result.outcome)
          log_fault($sformatf("outcome got %0d want %0d", outcome_o,
                              oldest_result.outcome));
        if (slot_o !== oldest_result.slot)
          log_fault($sformatf("slot got %0d want %0d", slot_o, oldest_result.slot));
        if (evicted_o !== oldest_result.evicted)
          log_fault($sformatf("evicted got %b want %b", evicted_o,
                              oldest_result.evicted));
        if (miss_bytes_total_o !== oldest_result.miss_total)
          log_fault($sformatf("miss_bytes_total got %h want %h", miss_bytes_total_o,
                              oldest_result.miss_total));
        if (ref_bytes_total_o !== oldest_result.ref_total)
          log_fault($sformatf("ref_bytes_total got %h want %h", ref_bytes_total_o,
                              oldest_result.ref_total));
      end
    end
  end

  // Watchdog: drop the run if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lookahead_min_slot_replacement_unit_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t acc;
    int pick;
    logic [WEIGHT_W-1:0] now_time;

    fault_count    = 0;
    cycle_count    = 0;
    burst_left     = 0;
    now_time       = '0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    row_id_i       = '0;
    part_id_i      = '0;
    access_bytes_i = '0;
    next_use_i     = '0;

    // Reset state of the shadow cache: empty slots weigh the most.
    for (int i = 0; i < NUM_SLOT; i++) begin
      shadow_tag[i]    = '0;
      shadow_valid[i]  = 1'b0;
      shadow_weight[i] = EMPTY_WEIGHT;
    end
    shadow_miss_bytes = '0;
    shadow_ref_bytes  = '0;

    // Working set for the random part; about 1.5x the slot count so that
    // hits, fills, evictions and bypasses all keep occurring.
    for (int i = 0; i < TAG_POOL_DEPTH; i++) begin
      pool_row[i]  = ROW_W'($urandom());
      pool_part[i] = PART_W'($urandom());
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) send_access(directed_rows[i]);

    // Fill the cache to the brim with short next uses: empties go first,
    // then the far-future slots are evicted, then the later accesses bypass.
    for (int i = 0; i < 70; i++) begin
      acc          = '0;
      acc.row      = ROW_W'(24'h100000 + i);
      acc.part     = PART_W'(i);
      acc.nbytes   = BYTES_W'($urandom());
      acc.next_use = WEIGHT_W'(1000 + i);
      send_access(acc);
    end
    // Full cache, every weight smaller than never: bypass.
    acc          = '0;
    acc.row      = 24'h0F0F0F;
    acc.part     = 8'hF0;
    acc.nbytes   = 12'hFFF;
    acc.next_use = NEVER_USE;
    send_access(acc);

    // Random part: mostly the working set with a rolling notion of time,
    // some fully random tags and next uses as noise.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      acc = '0;
      if ($urandom_range(0, 99) < 85) begin
        pick     = $urandom_range(0, TAG_POOL_DEPTH - 1);
        acc.row  = pool_row[pick];
        acc.part = pool_part[pick];
      end else begin
        acc.row  = ROW_W'($urandom());
        acc.part = PART_W'($urandom());
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      acc.nbytes = '0;
      else if (pick == 1) acc.nbytes = '1;
      else                acc.nbytes = BYTES_W'($urandom());
      now_time = now_time + WEIGHT_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 20)      acc.next_use = NEVER_USE;
      else if (pick < 35) acc.next_use = $urandom_range(0, 32'hFFFF_FFFE);
      else if (pick < 40) acc.next_use = WEIGHT_W'($urandom_range(0, 3));
      else                acc.next_use = now_time + WEIGHT_W'($urandom_range(1, 300));
      send_access(acc);
    end

    @(negedge clk_i);
    start_i <= 1'b0;

    // Drain, then hold a chain's length longer to catch stray strobes.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      log_fault($sformatf("%0d results never arrived", pending_results.size()));

    if (fault_count == 0) begin
      $display("lookahead_min_slot_replacement_unit_tb passed");
    end else begin
      $display("lookahead_min_slot_replacement_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lmsr_pkg.sv
rtl/lmsr_cell.sv
rtl/lookahead_min_slot_replacement_unit.sv
verif/lookahead_min_slot_replacement_unit_tb.sv
